@@ sv/cursor_linked_list_engine_assert.svh @@
// Assertion macros shared by the cursor linked list engine RTL.
// Expects signals named clock and reset (synchronous, active high) in scope.
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define CLLE_ASSERT_HOLD(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("clle invariant violated");

// consequent must hold in the cycle after the antecedent
`define CLLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clle next-cycle check failed");

`endif

@@ sv/clle_pkg.sv @@
// Shared types and constants for the cursor linked list engine.
// No dependencies; used by clle_ram, clle_ctrl, clle_dpath and the top level.
package clle_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int OP_W       = 2;
   localparam int POS_W      = 5;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 5;
   localparam int STAT_W     = 3;
   localparam int REQ_DATA_W = 40;  // position, value, zero pad
   localparam int RSP_DATA_W = 48;  // data_out, found_position, entry_count, zero pad

   // link codes: free, end of list, next slot k coded as LINK_BASE + k
   localparam int LINK_FREE = 0;
   localparam int LINK_END  = 1;
   localparam int LINK_BASE = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_RETRIEVE = 2'd2,
      OP_SEARCH   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_BADPOS   = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_INS_HEAD,
      S_INS_LINK,
      S_INS_PREV,
      S_DEL_UNLINK,
      S_DEL_FREE,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       clear_wr;
      logic       scan_start;
      logic       scan_next;
      logic       rd_free;
      logic       walk_start;
      logic       walk_next;
      logic       capture;
      logic       ins_head;
      logic       ins_link;
      logic       ins_prev;
      logic       del_unlink;
      logic       del_free;
      logic       set_status;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   ins_pos_bad;
      logic   dr_pos_bad;
      logic   len_zero;
      logic   pos_one;
      logic   link_free;
      logic   at_target;
      logic   at_end;
      logic   val_match;
      logic   clear_last;
      logic   out_free;
   } sts_type;

endpackage

@@ sv/cursor_linked_list_engine.sv @@
// Cursor linked list engine: one insert/delete/retrieve/search per transfer.
// Each slot visited in the free scan or the list walk takes a read state and a check
// state, since the link memory has a registered read port.
// One operation at a time: no new request is taken until the last one's result is
// loaded, but a new request is taken while a result waits for rsp_tready. After reset
// a clearing pass frees all links, with req_tready low.
module cursor_linked_list_engine #(
   parameter int MAX_ENTRIES = clle_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [4:0] position, [36:5] value, [39:37] zero
   input  logic [clle_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [clle_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] data_out, [36:32] found_position, [41:37] entry_count, [47:42] zero
   output logic [clle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [clle_pkg::STAT_W-1:0]     rsp_tuser
);

   clle_pkg::cmd_type cmd;
   clle_pkg::sts_type sts;

   clle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   clle_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/clle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on clle_pkg for default sizes.
module clle_ram #(
   parameter int WIDTH = clle_pkg::VAL_W,
   parameter int DEPTH = clle_pkg::MAX_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/clle_ctrl.sv @@
// Sequencer for the cursor linked list engine: one operation at a time.
// Depends on clle_pkg (state, command and status types); drives clle_dpath.
module clle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  clle_pkg::sts_type sts,
   output clle_pkg::cmd_type cmd
);

   clle_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clle_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         clle_pkg::S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = clle_pkg::S_IDLE;
            end
         end
         clle_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = clle_pkg::S_CHECK;
            end
         end
         clle_pkg::S_CHECK: begin
            cmd.set_status = 1'b1;
            case (sts.op)
               clle_pkg::OP_INSERT: begin
                  if (sts.full) begin
                     cmd.status = clle_pkg::STAT_FULL;
                     state_in   = clle_pkg::S_RESP;
                  end else if (sts.ins_pos_bad) begin
                     cmd.status = clle_pkg::STAT_BADPOS;
                     state_in   = clle_pkg::S_RESP;
                  end else begin
                     cmd.status     = clle_pkg::STAT_OK;
                     cmd.scan_start = 1'b1;
                     state_in       = clle_pkg::S_SCAN_RD;
                  end
               end
               clle_pkg::OP_DELETE, clle_pkg::OP_RETRIEVE: begin
                  if (sts.len_zero) begin
                     cmd.status = clle_pkg::STAT_EMPTY;
                     state_in   = clle_pkg::S_RESP;
                  end else if (sts.dr_pos_bad) begin
                     cmd.status = clle_pkg::STAT_BADPOS;
                     state_in   = clle_pkg::S_RESP;
                  end else begin
                     cmd.status     = clle_pkg::STAT_OK;
                     cmd.walk_start = 1'b1;
                     state_in       = clle_pkg::S_WALK_RD;
                  end
               end
               clle_pkg::OP_SEARCH: begin
                  if (sts.len_zero) begin
                     cmd.status = clle_pkg::STAT_EMPTY;
                     state_in   = clle_pkg::S_RESP;
                  end else begin
                     cmd.status     = clle_pkg::STAT_OK;
                     cmd.walk_start = 1'b1;
                     state_in       = clle_pkg::S_WALK_RD;
                  end
               end
               default: begin
                  state_in = clle_pkg::S_IDLE;
               end
            endcase
         end
         clle_pkg::S_SCAN_RD: begin
            cmd.rd_free = 1'b1;
            state_in    = clle_pkg::S_SCAN_CHK;
         end
         clle_pkg::S_SCAN_CHK: begin
            if (sts.link_free) begin
               if (sts.pos_one) begin
                  state_in = clle_pkg::S_INS_HEAD;
               end else begin
                  cmd.walk_start = 1'b1;
                  state_in       = clle_pkg::S_WALK_RD;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = clle_pkg::S_SCAN_RD;
            end
         end
         clle_pkg::S_WALK_RD: begin
            state_in = clle_pkg::S_WALK_CHK;
         end
         clle_pkg::S_WALK_CHK: begin
            if (sts.op == clle_pkg::OP_SEARCH) begin
               if (sts.val_match) begin
                  state_in = clle_pkg::S_RESP;
               end else if (sts.at_end) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = clle_pkg::STAT_NOTFOUND;
                  state_in       = clle_pkg::S_RESP;
               end else begin
                  cmd.walk_next = 1'b1;
                  state_in      = clle_pkg::S_WALK_RD;
               end
            end else if (sts.at_target) begin
               cmd.capture = 1'b1;
               case (sts.op)
                  clle_pkg::OP_INSERT: state_in = clle_pkg::S_INS_LINK;
                  clle_pkg::OP_DELETE: state_in = clle_pkg::S_DEL_UNLINK;
                  default:             state_in = clle_pkg::S_RESP;
               endcase
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = clle_pkg::S_WALK_RD;
            end
         end
         clle_pkg::S_INS_HEAD: begin
            cmd.ins_head = 1'b1;
            state_in     = clle_pkg::S_RESP;
         end
         clle_pkg::S_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = clle_pkg::S_INS_PREV;
         end
         clle_pkg::S_INS_PREV: begin
            cmd.ins_prev = 1'b1;
            state_in     = clle_pkg::S_RESP;
         end
         clle_pkg::S_DEL_UNLINK: begin
            cmd.del_unlink = 1'b1;
            state_in       = clle_pkg::S_DEL_FREE;
         end
         clle_pkg::S_DEL_FREE: begin
            cmd.del_free = 1'b1;
            state_in     = clle_pkg::S_RESP;
         end
         clle_pkg::S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = clle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = clle_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/clle_dpath.sv @@
// Datapath for the cursor linked list engine: slot memories, list pointers,
// walk counters and the result register. Depends on clle_pkg, clle_ram and the assertion header.
`include "cursor_linked_list_engine_assert.svh"

module clle_dpath #(
   parameter int MAX_ENTRIES = clle_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  clle_pkg::cmd_type                 cmd,
   output clle_pkg::sts_type                 sts,
   input  logic [clle_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [clle_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [clle_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [clle_pkg::STAT_W-1:0]       rsp_tuser
);

   localparam int SW   = $clog2(MAX_ENTRIES);
   localparam int LW   = $clog2(MAX_ENTRIES + clle_pkg::LINK_BASE);
   localparam int LENW = $clog2(MAX_ENTRIES + 1);
   localparam int CW   = (LENW > clle_pkg::POS_W) ? LENW : clle_pkg::POS_W;
   localparam int POSW = clle_pkg::POS_W;
   localparam int VW   = clle_pkg::VAL_W;
   localparam int CTW  = clle_pkg::CNT_W;
   localparam logic [LENW-1:0] MAX_LEN   = LENW'(MAX_ENTRIES);
   localparam logic [SW-1:0]   LAST_SLOT = SW'(MAX_ENTRIES - 1);
   localparam logic [LW-1:0]   CODE_FREE = LW'(clle_pkg::LINK_FREE);
   localparam logic [LW-1:0]   CODE_END  = LW'(clle_pkg::LINK_END);
   localparam logic [LW-1:0]   CODE_BASE = LW'(clle_pkg::LINK_BASE);

   clle_pkg::op_type     op_ff, op_in;
   logic [POSW-1:0]      pos_ff, pos_in;
   logic [VW-1:0]        val_ff, val_in;
   logic [LENW-1:0]      len_ff, len_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic [SW-1:0]        free_ff, free_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        tgt_ff, tgt_in;
   logic [LW-1:0]        link_sv_ff, link_sv_in;
   logic [VW-1:0]        data_sv_ff, data_sv_in;
   clle_pkg::status_type stat_ff, stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_data_ff, rsp_data_in;
   logic [CTW-1:0]       rsp_found_ff, rsp_found_in;
   logic [CTW-1:0]       rsp_count_ff, rsp_count_in;
   clle_pkg::status_type rsp_stat_ff, rsp_stat_in;

   logic [LW-1:0]   rd_link;
   logic [VW-1:0]   rd_value;
   logic [SW-1:0]   rd_addr;
   logic            lk_we;
   logic [SW-1:0]   lk_waddr;
   logic [LW-1:0]   lk_wdata;
   logic            vl_we;

   logic [CW-1:0]   pos_ext;
   logic [CW-1:0]   len_ext;
   logic [LW-1:0]   rd_link_off;
   logic [LW-1:0]   sv_link_off;
   logic [SW-1:0]   rd_next_slot;
   logic [SW-1:0]   sv_next_slot;
   logic [LW-1:0]   head_code;
   logic [LW-1:0]   free_code;
   logic            len_one;
   logic            out_free;

   assign pos_ext      = CW'(pos_ff);
   assign len_ext      = CW'(len_ff);
   assign rd_link_off  = rd_link - CODE_BASE;
   assign sv_link_off  = link_sv_ff - CODE_BASE;
   assign rd_next_slot = rd_link_off[SW-1:0];
   assign sv_next_slot = sv_link_off[SW-1:0];
   assign head_code    = LW'(head_ff) + CODE_BASE;
   assign free_code    = LW'(free_ff) + CODE_BASE;
   assign len_one      = (len_ff == LENW'(1));
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // the scan for a free slot reads at free_ff, everything else at the walk cursor
   assign rd_addr = cmd.rd_free ? free_ff : cur_ff;
   assign vl_we   = cmd.ins_head || cmd.ins_link;

   always_comb begin
      lk_we    = 1'b0;
      lk_waddr = free_ff;
      lk_wdata = CODE_FREE;
      if (cmd.clear_wr) begin
         lk_we = 1'b1;
      end else if (cmd.ins_head) begin
         lk_we    = 1'b1;
         lk_wdata = (len_ff == '0) ? CODE_END : head_code;
      end else if (cmd.ins_link) begin
         lk_we    = 1'b1;
         lk_wdata = link_sv_ff;
      end else if (cmd.ins_prev) begin
         lk_we    = 1'b1;
         lk_waddr = cur_ff;
         lk_wdata = free_code;
      end else if (cmd.del_unlink && !sts.pos_one) begin
         lk_we    = 1'b1;
         lk_waddr = prev_ff;
         lk_wdata = link_sv_ff;
      end else if (cmd.del_free) begin
         lk_we    = 1'b1;
         lk_waddr = cur_ff;
      end
   end

   clle_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_ENTRIES)
   ) u_links (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   clle_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ENTRIES)
   ) u_values (
      .clock   (clock),
      .wr_en   (vl_we),
      .wr_addr (free_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_value)
   );

   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      free_in      = free_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      link_sv_in   = link_sv_ff;
      data_sv_in   = data_sv_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_stat_in  = rsp_stat_ff;

      if (cmd.accept) begin
         op_in  = clle_pkg::op_type'(req_tuser);
         pos_in = req_tdata[POSW-1:0];
         val_in = req_tdata[POSW +: VW];
      end
      if (cmd.clear_wr || cmd.scan_next) begin
         free_in = free_ff + SW'(1);
      end
      if (cmd.scan_start) begin
         free_in = '0;
      end
      if (cmd.walk_start) begin
         cur_in  = head_ff;
         prev_in = head_ff;
         idx_in  = CW'(1);
         // insert stops on the entry before the new one
         tgt_in  = (op_ff == clle_pkg::OP_INSERT) ? pos_ext - CW'(1) : pos_ext;
      end
      if (cmd.walk_next) begin
         prev_in = cur_ff;
         cur_in  = rd_next_slot;
         idx_in  = idx_ff + CW'(1);
      end
      if (cmd.capture) begin
         link_sv_in = rd_link;
         data_sv_in = rd_value;
      end
      if (cmd.ins_head) begin
         head_in    = free_ff;
         len_in     = len_ff + LENW'(1);
         data_sv_in = val_ff;
      end
      if (cmd.ins_link) begin
         data_sv_in = val_ff;
      end
      if (cmd.ins_prev) begin
         len_in = len_ff + LENW'(1);
      end
      if (cmd.del_unlink && sts.pos_one) begin
         head_in = len_one ? '0 : sv_next_slot;
      end
      if (cmd.del_free) begin
         len_in = len_ff - LENW'(1);
      end
      if (cmd.set_status) begin
         stat_in = cmd.status;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = stat_ff;
         rsp_count_in = len_ext[CTW-1:0];
         rsp_data_in  = ((stat_ff == clle_pkg::STAT_OK) && (op_ff != clle_pkg::OP_SEARCH))
                        ? data_sv_ff : '0;
         rsp_found_in = ((stat_ff == clle_pkg::STAT_OK) && (op_ff == clle_pkg::OP_SEARCH))
                        ? idx_ff[CTW-1:0] : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      idx_ff       <= idx_in;
      tgt_ff       <= tgt_in;
      link_sv_ff   <= link_sv_in;
      data_sv_ff   <= data_sv_in;
      stat_ff      <= stat_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   always_comb begin
      sts             = '0;
      sts.op          = op_ff;
      sts.full        = (len_ff == MAX_LEN);
      sts.ins_pos_bad = (pos_ff == '0) || ({1'b0, pos_ext} > ({1'b0, len_ext} + (CW+1)'(1)));
      sts.dr_pos_bad  = (pos_ff == '0) || (pos_ext > len_ext);
      sts.len_zero    = (len_ff == '0);
      sts.pos_one     = (pos_ff == POSW'(1));
      sts.link_free   = (rd_link == CODE_FREE);
      sts.at_target   = (idx_ff == tgt_ff);
      sts.at_end      = (idx_ff == len_ext);
      sts.val_match   = (rd_value == val_ff);
      sts.clear_last  = (free_ff == LAST_SLOT);
      sts.out_free    = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(clle_pkg::RSP_DATA_W - VW - 2*CTW)'(0), rsp_count_ff, rsp_found_ff,
                        rsp_data_ff};
   assign rsp_tuser  = rsp_stat_ff;

   `CLLE_ASSERT_HOLD(a_len_bound, len_ff <= MAX_LEN)
   `CLLE_ASSERT_HOLD(a_load_when_free, !cmd.rsp_load || out_free)
   `CLLE_ASSERT_HOLD(a_walk_in_list, !cmd.walk_next || (idx_ff < len_ext))
   `CLLE_ASSERT_NEXT(a_ins_grows, cmd.ins_head || cmd.ins_prev, len_ff == $past(len_ff) + LENW'(1))
   `CLLE_ASSERT_NEXT(a_del_shrinks, cmd.del_free, len_ff == $past(len_ff) - LENW'(1))

endmodule
